>>> design/nti_pkg.sv
// Shared types and codes for the next-time-in-interval schedule unit.
// No dependencies; imported by the control, top level and checker files.
package nti_pkg;

    // item kinds on the input side
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_REWIND = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;
    localparam logic [1:0] OP_SAMPLE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_LOADED = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    localparam logic [31:0] TIME_NONE = 32'hFFFF_FFFF;
    localparam logic [31:0] TIME_MAX  = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] event_time;
    } t_result;

endpackage

>>> design/nti_mem.sv
// Window table: one write port, one read port, registered read data.
// Each entry holds {begin, end}. No package dependency.
module nti_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/nti_ctrl.sv
// Sequencer for the schedule unit: cursor, base time, window scan and result register.
// Depends on nti_pkg; drives the ports of nti_mem.
module nti_ctrl
    import nti_pkg::*;
#(
    parameter int MAX_WINDOWS = 1024,
    parameter int AW          = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_wdata,
    // input item
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [9:0]         i_slot,
    input  logic signed [31:0] i_begin_time,
    input  logic signed [31:0] i_end_time,
    input  logic signed [31:0] i_start_time,
    input  logic [15:0]        i_step_delay,
    // result item
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_result            o_out_res,
    // window table
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [63:0]        o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [63:0]        i_mem_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [17:0] MAX_CNT = 18'(MAX_WINDOWS);

    logic [1:0]         r_state, n_state;
    logic [AW-1:0]      r_cursor, n_cursor;
    logic [AW-1:0]      r_last;
    logic signed [31:0] r_base, n_base;
    logic               r_exh, n_exh;
    logic signed [31:0] r_t, n_t;
    t_result            r_pend, n_pend;
    logic               r_ovalid, n_ovalid;
    t_result            r_ores, n_ores;

    logic               emit_req;
    t_result            emit_res;
    logic               out_free;
    logic               reject;
    logic [32:0]        sum;
    logic [AW-1:0]      cur_cl;
    logic [17:0]        cfg_cnt;
    logic signed [31:0] rd_begin, rd_end;

    assign rd_begin = i_mem_rdata[63:32];
    assign rd_end   = i_mem_rdata[31:0];
    assign out_free = !r_ovalid || i_out_ready;

    // saturating base + delay; delay is never negative so only the top can overflow
    assign sum    = {r_base[31], r_base} + {17'd0, i_step_delay};
    assign cur_cl = (r_cursor > r_last) ? r_last : r_cursor;
    assign reject = ({8'd0, i_slot} >= MAX_CNT) || (i_begin_time > i_end_time);

    // window count clamped to 1..MAX_WINDOWS, kept as the last usable index
    always_comb begin
        cfg_cnt = {7'd0, i_cfg_wdata};
        if (cfg_cnt == 18'd0) begin
            cfg_cnt = 18'd1;
        end
        if (cfg_cnt > MAX_CNT) begin
            cfg_cnt = MAX_CNT;
        end
    end

    // main sequencer
    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_base      = r_base;
        n_exh       = r_exh;
        n_t         = r_t;
        n_pend      = r_pend;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_ores      = r_ores;
        emit_req    = 1'b0;
        emit_res    = '{status: ST_NONE, event_time: TIME_NONE};
        o_mem_we    = 1'b0;
        o_mem_raddr = r_cursor;
        o_in_ready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        OP_LOAD: begin
                            o_mem_we        = !reject;
                            emit_req        = 1'b1;
                            emit_res.status = reject ? ST_REJECT : ST_LOADED;
                        end
                        OP_REWIND: begin
                            n_cursor = '0;
                            n_exh    = 1'b0;
                        end
                        OP_START: begin
                            n_base = i_start_time;
                        end
                        default: begin
                            if (r_exh) begin
                                emit_req = 1'b1;
                            end else begin
                                n_t         = (!sum[32] && sum[31]) ? TIME_MAX : sum[31:0];
                                n_cursor    = cur_cl;
                                o_mem_raddr = cur_cl;
                                n_state     = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                // window at r_cursor is on the read port this cycle
                if (rd_end < r_t && r_cursor != r_last) begin
                    n_cursor    = r_cursor + 1'b1;
                    o_mem_raddr = r_cursor + 1'b1;
                end else if (rd_end >= r_t) begin
                    n_state = S_IDLE;
                    if (rd_begin <= r_t) begin
                        n_base   = r_t;
                        emit_req = 1'b1;
                        emit_res = '{status: ST_FOUND, event_time: r_t};
                    end else begin
                        n_base = rd_begin;
                    end
                end else begin
                    n_state  = S_IDLE;
                    n_exh    = 1'b1;
                    emit_req = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_pend;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // result goes straight to the output register, or parks until it frees up
        if (emit_req) begin
            if (out_free) begin
                n_ovalid = 1'b1;
                n_ores   = emit_res;
            end else begin
                n_pend  = emit_res;
                n_state = S_EMIT;
            end
        end
    end

    assign o_mem_waddr = AW'(i_slot);
    assign o_mem_wdata = {i_begin_time, i_end_time};
    assign o_out_valid = r_ovalid;
    assign o_out_res   = r_ores;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_base   <= '0;
            r_exh    <= 1'b0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_base   <= n_base;
            r_exh    <= n_exh;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_last <= AW'(cfg_cnt - 18'd1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_pend <= n_pend;
        r_ores <= n_ores;
    end

endmodule

>>> design/next_time_in_interval_schedule_unit.sv
// Next-time-in-interval schedule unit: top level with stream ports.
// Depends on nti_pkg, nti_ctrl and nti_mem.
//
// Keeps a table of closed time windows, a forward-only cursor and a base time.
// Load, rewind and start are taken in the idle state. Unless exhausted, a
// sample reads one window plus one per skipped window: the single read port of
// the window memory delivers one window per cycle and the sequencer compares
// it against the target time before moving on. Since the cursor never moves
// backward until a rewind, skipping averages out to about one read per sample.
// A result waits in an output register while the next item is taken; a second
// result stalls the unit until the first is taken. The table is not cleared
// at reset, so windows must be loaded before they are reached by the cursor.
module next_time_in_interval_schedule_unit
    import nti_pkg::*;
#(
    parameter int MAX_WINDOWS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // window count register
    input  logic         i_cfg_we,
    input  logic [10:0]  i_cfg_wdata,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // slot[9:0], begin_time[41:10], end_time[73:42],
                                        // start_time[105:74], step_delay[121:106], zero pad
    input  logic [1:0]   s_axis_tuser,  // op[1:0]
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // event_time[31:0]
    output logic [1:0]   m_axis_tuser   // status[1:0]
);

    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [63:0]   mem_rdata;
    t_result       out_res;

    // sequencer
    nti_ctrl #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .AW          (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_slot       (s_axis_tdata[9:0]),
        .i_begin_time (s_axis_tdata[41:10]),
        .i_end_time   (s_axis_tdata[73:42]),
        .i_start_time (s_axis_tdata[105:74]),
        .i_step_delay (s_axis_tdata[121:106]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_res    (out_res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    // window table
    nti_mem #(
        .DEPTH (MAX_WINDOWS),
        .AW    (AW),
        .DW    (64)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tdata = out_res.event_time;
    assign m_axis_tuser = out_res.status;

endmodule

>>> design/nti_checker.sv
// Port-level checks for the schedule unit, bound to the top level.
// Depends on nti_pkg.
module nti_checker
    import nti_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // a result item never carries unknown bits
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown({m_axis_tuser, m_axis_tdata}))
        else $error("result item has unknown bits");

    // every other status carries the none marker
    a_none_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_FOUND |-> m_axis_tdata == TIME_NONE)
        else $error("non-found result carries a time");

endmodule

bind next_time_in_interval_schedule_unit nti_checker u_nti_checker (.*);
